// ===== src/pipl_pkg.sv =====
// Shared types, codes and defaults for the point-in-polygon locator.
`timescale 1ns / 1ps

package pipl_pkg;

  localparam int MAX_VERTICES_DEF = 256;
  localparam int COORD_BITS_DEF   = 16;
  localparam int FIELD_BITS       = 16;
  localparam int MIN_VERTICES     = 3;

  typedef enum logic {
    REQ_ADD   = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    POS_EXTERIOR = 2'd0,
    POS_INTERIOR = 2'd1,
    POS_EDGE     = 2'd2,
    POS_VERTEX   = 2'd3
  } pos_t;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_FEW = 1'b1;

  typedef struct packed {
    logic                          req_type;
    logic signed [FIELD_BITS-1:0]  coord_x;
    logic signed [FIELD_BITS-1:0]  coord_y;
    logic                          start_new;
  } in_t;

  typedef struct packed {
    logic [1:0] position;
    logic       status;
    logic       overflow;
  } out_t;

  // control from the sequencer to the edge unit
  typedef struct packed {
    logic clear;
    logic valid;
    logic first;
  } eu_ctrl_t;

  // status from the edge unit back to the sequencer
  typedef struct packed {
    logic busy;
    logic rpar;
    logic lpar;
    logic hit;
  } eu_stat_t;

endpackage

// ===== src/pipl_vstore.sv =====
// Vertex store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module pipl_vstore #(
  parameter int DEPTH = pipl_pkg::MAX_VERTICES_DEF,
  parameter int WIDTH = 2 * pipl_pkg::COORD_BITS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/pipl_edge_unit.sv =====
// Edge crossing pipeline: shift to query origin, cross products, parity update.
`timescale 1ns / 1ps

module pipl_edge_unit #(
  parameter int COORD_BITS = pipl_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pipl_pkg::eu_ctrl_t           ctrl,
  input  logic signed [COORD_BITS-1:0] vx,
  input  logic signed [COORD_BITS-1:0] vy,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  output pipl_pkg::eu_stat_t           stat
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] dx, dy;
  logic signed [DW-1:0] xi, yi, xj, yj;
  logic                 s1_valid, s1_edge;
  logic signed [PW-1:0] p1, p2;
  logic                 s2_valid, rs, ls, dpos, vmatch;
  logic                 rpar, lpar, hit;
  logic                 gt, lt;

  assign dx = DW'(vx) - DW'(px);
  assign dy = DW'(vy) - DW'(py);
  assign gt = p1 > p2;
  assign lt = p1 < p2;

  // stage 1: shifted current vertex, previous one kept as the edge start
  always_ff @(posedge clk) begin
    if (ctrl.valid) begin
      xi <= dx;
      yi <= dy;
      xj <= xi;
      yj <= yi;
      s1_edge <= !ctrl.first;
    end
  end

  // stage 2: cross products and straddle tests
  always_ff @(posedge clk) begin
    if (s1_valid && s1_edge) begin
      p1     <= xi * yj;
      p2     <= xj * yi;
      rs     <= (yi > 0) != (yj > 0);
      ls     <= (yi < 0) != (yj < 0);
      dpos   <= yj > yi;
      vmatch <= (xi == '0) && (yi == '0);
    end
  end

  // stage 3: parity accumulation; a zero numerator never flips
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      rpar     <= 1'b0;
      lpar     <= 1'b0;
      hit      <= 1'b0;
    end else begin
      s1_valid <= ctrl.valid;
      s2_valid <= s1_valid && s1_edge;
      if (s2_valid) begin
        if (rs && (dpos ? gt : lt)) begin
          rpar <= !rpar;
        end
        if (ls && (dpos ? lt : gt)) begin
          lpar <= !lpar;
        end
        if (vmatch) begin
          hit <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = s1_valid || s2_valid;
  assign stat.rpar = rpar;
  assign stat.lpar = lpar;
  assign stat.hit  = hit;

endmodule

// ===== src/point_in_polygon_locate_top.sv =====
// Point-in-polygon locator top level: command port, sequencer, store and edge unit.
`timescale 1ns / 1ps

// A vertex word (req_type add) leaves busy low, so the next word may
// follow at once; start_new empties the polygon first, and vertices beyond
// MAX_VERTICES are dropped with the sticky overflow flag set. A query word
// on fewer than three vertices answers on the next cycle with status set.
// Otherwise the query walks the store, one memory read per vertex plus one
// for the closing edge; busy stays high through the walk and falls in the
// cycle in which the result strobe done rises. done is high for a single
// cycle and the receiver cannot hold it off; the result must be captured in
// that cycle.
module point_in_polygon_locate_top #(
  parameter int MAX_VERTICES = pipl_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pipl_pkg::COORD_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  pipl_pkg::in_t  word,
  output logic           busy,
  output logic           done,
  output pipl_pkg::out_t result
);

  localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int MW    = 2 * COORD_BITS;

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    DRAIN
  } state_t;

  state_t state;

  logic [CNT_W-1:0]             count, cnt_base, k;
  logic                         dropped;
  logic signed [COORD_BITS-1:0] px, py, cx, cy;
  logic                         rd_valid, first;
  logic                         accept, add_acc, query_acc, add_fits;
  logic                         we, re;
  logic [AW-1:0]                waddr, raddr;
  logic [MW-1:0]                wdata, rdata;
  pipl_pkg::eu_ctrl_t           eu_ctrl;
  pipl_pkg::eu_stat_t           eu_stat;
  pipl_pkg::pos_t               pos;

  assign busy      = state != IDLE;
  assign accept    = start && !busy;
  assign add_acc   = accept && (word.req_type == pipl_pkg::REQ_ADD);
  assign query_acc = accept && (word.req_type == pipl_pkg::REQ_QUERY);

  // low COORD_BITS of the field, read as two's complement
  assign cx = COORD_BITS'(word.coord_x);
  assign cy = COORD_BITS'(word.coord_y);

  assign cnt_base = word.start_new ? '0 : count;
  assign add_fits = cnt_base < CNT_W'(MAX_VERTICES);

  assign we    = add_acc && add_fits;
  assign waddr = AW'(cnt_base);
  assign wdata = {cy, cx};

  // read vertex n-1 first so that it opens the closing edge
  assign re    = state == RUN;
  assign raddr = (k == '0) ? AW'(count - 1'b1) : AW'(k - 1'b1);

  assign eu_ctrl.clear = query_acc;
  assign eu_ctrl.valid = rd_valid;
  assign eu_ctrl.first = first;

  always_comb begin
    priority if (eu_stat.hit) begin
      pos = pipl_pkg::POS_VERTEX;
    end else if (eu_stat.rpar != eu_stat.lpar) begin
      pos = pipl_pkg::POS_EDGE;
    end else if (eu_stat.rpar) begin
      pos = pipl_pkg::POS_INTERIOR;
    end else begin
      pos = pipl_pkg::POS_EXTERIOR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      done     <= 1'b0;
      count    <= '0;
      dropped  <= 1'b0;
      k        <= '0;
      rd_valid <= 1'b0;
      first    <= 1'b0;
    end else begin
      done     <= 1'b0;
      rd_valid <= state == RUN;
      first    <= (state == RUN) && (k == '0);
      unique case (state)
        IDLE: begin
          if (add_acc) begin
            if (add_fits) begin
              count <= cnt_base + 1'b1;
            end
            if (word.start_new) begin
              dropped <= !add_fits;
            end else if (!add_fits) begin
              dropped <= 1'b1;
            end
          end else if (query_acc) begin
            px <= cx;
            py <= cy;
            if (count < CNT_W'(pipl_pkg::MIN_VERTICES)) begin
              done            <= 1'b1;
              result.position <= pipl_pkg::POS_EXTERIOR;
              result.status   <= pipl_pkg::STATUS_FEW;
              result.overflow <= dropped;
            end else begin
              k     <= '0;
              state <= RUN;
            end
          end
        end
        RUN: begin
          k <= k + 1'b1;
          if (k == count) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (!rd_valid && !eu_stat.busy) begin
            done            <= 1'b1;
            result.position <= pos;
            result.status   <= pipl_pkg::STATUS_OK;
            result.overflow <= dropped;
            state           <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  pipl_vstore #(
    .DEPTH(MAX_VERTICES),
    .WIDTH(MW),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  pipl_edge_unit #(
    .COORD_BITS(COORD_BITS)
  ) u_edge (
    .clk (clk),
    .rst (rst),
    .ctrl(eu_ctrl),
    .vx  (rdata[COORD_BITS-1:0]),
    .vy  (rdata[MW-1:COORD_BITS]),
    .px  (px),
    .py  (py),
    .stat(eu_stat)
  );

endmodule

// ===== src/pipl_checker.sv =====
// Port-level checks for the point-in-polygon locator, bound to the top level.
`timescale 1ns / 1ps

module pipl_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input pipl_pkg::in_t  word,
  input logic           busy,
  input logic           done,
  input pipl_pkg::out_t result
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done && !busy)
    else $error("done or busy high after reset");

  a_add_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (word.req_type == pipl_pkg::REQ_ADD) |=> !done)
    else $error("vertex word produced a result");

  a_query_taken: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (word.req_type == pipl_pkg::REQ_QUERY) |=> done || busy)
    else $error("query word neither answered nor in progress");

  a_few_exterior: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == pipl_pkg::STATUS_OK) ||
             (result.position == pipl_pkg::POS_EXTERIOR))
    else $error("short polygon result not exterior");

  a_end_strobe: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> done)
    else $error("walk ended without a result");

endmodule

bind point_in_polygon_locate_top pipl_checker u_chk (.*);
